// ----- rtl/uks_pkg.sv -----
// ----------------------------------------------------------------------------
// uks_pkg
// Shared widths, operation and status codes, and the command bundle between
// the controller and the datapath of the unique key set table.
// ----------------------------------------------------------------------------
package uks_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 64;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam int S_FIELDS_W = MODE_W + KEY_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = 1 + SLOT_W + COUNT_W + STATUS_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam mode_t MODE_LOOKUP = 2'd0;
  localparam mode_t MODE_INSERT = 2'd1;
  localparam mode_t MODE_REMOVE = 2'd2;

  localparam status_t ST_DONE     = 2'd0;
  localparam status_t ST_DUP      = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic load;     // take a new word from the input
    logic capture;  // compare key against all cells
    logic commit;   // apply the operation, load the result register
  } dp_cmd_t;

endpackage

// ----- rtl/unique_key_set_table.sv -----
// ----------------------------------------------------------------------------
// unique_key_set_table
// Set of up to CAPACITY unique 64-bit keys kept in insertion order, with
// lookup, insert-if-absent and remove-with-compaction operations.
// ----------------------------------------------------------------------------
// Each accepted word is registered and then passes a compare step, in which
// every cell compares its key with the request in parallel and the match
// vector is registered, and a commit step, in which the slot is encoded, the
// table is updated (append or shift down) and the result register is loaded.
// A new word is taken in the same cycle as the previous one commits. A result
// held in the output register stalls the commit, and while a word waits to
// commit the input side takes no new word until that result has been taken.
// The table needs no clearing after reset.
module unique_key_set_table
  import uks_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // [1:0] mode, [65:2] key, rest zero
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // [0] found, [4:1] slot, [9:5] count,
                                         // [11:10] status, rest zero
);

  dp_cmd_t cmd;

  uks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  uks_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata)
  );

endmodule

// ----- rtl/uks_ctrl.sv -----
// ----------------------------------------------------------------------------
// uks_ctrl
// Sequencer: accept, compare, commit. Owns the handshakes on both sides.
// ----------------------------------------------------------------------------
module uks_ctrl
  import uks_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE   = 3'b001,
    MATCH  = 3'b010,
    UPDATE = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free    = !m_tvalid || m_tready;
  assign s_tready    = (state == IDLE) || ((state == UPDATE) && out_free);
  assign cmd.load    = s_tvalid && s_tready;
  assign cmd.capture = (state == MATCH);
  assign cmd.commit  = (state == UPDATE) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (cmd.load) state_next = MATCH;
      end
      MATCH: begin
        state_next = UPDATE;
      end
      UPDATE: begin
        if (out_free) state_next = cmd.load ? MATCH : IDLE;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/uks_datapath.sv -----
// ----------------------------------------------------------------------------
// uks_datapath
// Row of key cells with per-cell compare, fill counter, match register,
// slot encoder, compaction shift and result register.
// ----------------------------------------------------------------------------
module uks_datapath
  import uks_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)(
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [KEY_W-1:0]    cells [CAPACITY];
  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY-1:0] match_q;
  mode_t               mode_q;
  logic [KEY_W-1:0]    key_q;
  logic [CNT_W-1:0]    fill, fill_next;
  logic [IDX_W-1:0]    pos;
  logic                hit, full, do_insert, do_remove;
  status_t             status;
  logic [M_FIELDS_W-1:0] result;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec[i] = (cells[i] == key_q) && (CNT_W'(i) < fill);
    end
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_q[i]) pos = pos | IDX_W'(i);
    end
  end

  assign hit       = |match_q;
  assign full      = (fill == CNT_W'(CAPACITY));
  assign do_insert = (mode_q == MODE_INSERT) && !hit && !full;
  assign do_remove = (mode_q == MODE_REMOVE) && hit;

  always_comb begin
    fill_next = fill;
    if (do_insert) fill_next = fill + CNT_W'(1);
    else if (do_remove) fill_next = fill - CNT_W'(1);
  end

  always_comb begin
    case (mode_q)
      MODE_INSERT: status = hit ? ST_DUP : (full ? ST_FULL : ST_DONE);
      MODE_REMOVE: status = hit ? ST_DONE : ST_NOTFOUND;
      default:     status = hit ? ST_DONE : ST_NOTFOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= s_tdata[MODE_W-1:0];
      key_q  <= s_tdata[S_FIELDS_W-1:MODE_W];
    end
    if (cmd.capture) match_q <= hit_vec;
    if (cmd.commit) begin
      result <= {status, COUNT_W'(fill_next),
                 hit ? SLOT_W'(pos) : SLOT_W'(0), hit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.commit) begin
      fill <= fill_next;
    end
  end

  // cells: append at fill, on remove every cell from the hit up to the last but one takes its upper neighbor
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g < CAPACITY - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (cmd.commit) begin
          if (do_remove && (IDX_W'(g) >= pos)) begin
            cells[g] <= cells[g+1];
          end else if (do_insert && (CNT_W'(g) == fill)) begin
            cells[g] <= key_q;
          end
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (cmd.commit && do_insert && (CNT_W'(g) == fill)) begin
          cells[g] <= key_q;
        end
      end
    end
  end

  assign m_tdata = M_TDATA_W'(result);

endmodule

// ----- rtl/uks_checker.sv -----
// ----------------------------------------------------------------------------
// uks_checker
// Port-level checks on the unique key set table, bound to the top level.
// ----------------------------------------------------------------------------
module uks_checker
  import uks_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  logic                found;
  logic [SLOT_W-1:0]   slot;
  logic [COUNT_W-1:0]  count;
  status_t             status;

  assign found  = m_tdata[0];
  assign slot   = m_tdata[SLOT_W:1];
  assign count  = m_tdata[SLOT_W+COUNT_W:SLOT_W+1];
  assign status = m_tdata[M_FIELDS_W-1:SLOT_W+COUNT_W+1];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_miss_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !found |-> slot == '0 && status != ST_DUP)
    else $error("miss with nonzero slot or duplicate status");

  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && found |-> status == ST_DONE || status == ST_DUP)
    else $error("hit with full or not-found status");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == ST_FULL |-> count == COUNT_W'(CAPACITY))
    else $error("table full reported below capacity");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (CAPACITY > 31) || (count <= COUNT_W'(CAPACITY)))
    else $error("count above capacity");

endmodule

bind unique_key_set_table uks_checker #(
  .CAPACITY (CAPACITY)
) u_uks_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
